// ----- sv/segbox_pkg.sv -----
// Shared constants and types for the segment versus box bisection test.
package segbox_pkg;

   // Default sizes
   localparam int COORD_BITS_DEF  = 16;
   localparam int STACK_DEPTH_DEF = 32;

   // Fixed field widths
   localparam int EXTENT_BITS  = 16;
   localparam int CSR_ADDR_BITS = 3;
   localparam int RSP_BITS     = 8;

   // Smallest usable split limit
   localparam logic [EXTENT_BITS-1:0] EXTENT_FLOOR = EXTENT_BITS'(2);
   localparam logic [EXTENT_BITS-1:0] EXTENT_RESET = EXTENT_BITS'(2);

   // Register indexes of the configuration port
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_BOX_MIN_X  = 3'd0,
      CSR_BOX_MIN_Y  = 3'd1,
      CSR_BOX_MAX_X  = 3'd2,
      CSR_BOX_MAX_Y  = 3'd3,
      CSR_MIN_EXTENT = 3'd4
   } csr_idx_type;

   // Bit positions in the result tdata
   localparam int RSP_HIT_BIT     = 0;
   localparam int RSP_INVALID_BIT = 1;

   // Outcome of one axis interval check
   typedef enum logic [1:0] {
      AXIS_DISJOINT = 2'd0,
      AXIS_INSIDE   = 2'd1,
      AXIS_OVERLAP  = 2'd2
   } axis_type;

   // Outcome of one piece classification
   typedef enum logic [1:0] {
      PIECE_MISS  = 2'd0,
      PIECE_HIT   = 2'd1,
      PIECE_SPLIT = 2'd2
   } piece_class_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_CLASSIFY = 4'b0010,
      ST_POP      = 4'b0100,
      ST_FINISH   = 4'b1000
   } state_type;

endpackage

// ----- sv/segbox_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module segbox_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/segbox_classify.sv -----
// Classifies one segment piece against the box and computes its midpoint.
module segbox_classify #(
   parameter int COORD_BITS = segbox_pkg::COORD_BITS_DEF
) (
   input  logic signed [COORD_BITS-1:0]       ax,
   input  logic signed [COORD_BITS-1:0]       ay,
   input  logic signed [COORD_BITS-1:0]       bx,
   input  logic signed [COORD_BITS-1:0]       by,
   input  logic signed [COORD_BITS-1:0]       box_min_x,
   input  logic signed [COORD_BITS-1:0]       box_min_y,
   input  logic signed [COORD_BITS-1:0]       box_max_x,
   input  logic signed [COORD_BITS-1:0]       box_max_y,
   input  logic [segbox_pkg::EXTENT_BITS-1:0] min_extent,
   output segbox_pkg::piece_class_type        piece_class,
   output logic signed [COORD_BITS-1:0]       mid_x,
   output logic signed [COORD_BITS-1:0]       mid_y
);
   import segbox_pkg::*;

   localparam int CMP_BITS = (COORD_BITS > EXTENT_BITS) ? COORD_BITS : EXTENT_BITS;

   // Interval of a piece on one axis against the box interval
   function automatic axis_type axis_check(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b,
      input logic signed [COORD_BITS-1:0] lo_box,
      input logic signed [COORD_BITS-1:0] hi_box
   );
      logic signed [COORD_BITS-1:0] lo;
      logic signed [COORD_BITS-1:0] hi;
      axis_type res;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (hi < lo_box || hi_box < lo) begin
         res = AXIS_DISJOINT;
      end else if (lo_box <= lo && hi <= hi_box) begin
         res = AXIS_INSIDE;
      end else begin
         res = AXIS_OVERLAP;
      end
      return res;
   endfunction

   // Absolute difference, always fits unsigned in COORD_BITS
   function automatic logic [COORD_BITS-1:0] abs_diff(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b
   );
      logic signed [COORD_BITS:0] d;
      d = (a > b) ? ({a[COORD_BITS-1], a} - {b[COORD_BITS-1], b})
                  : ({b[COORD_BITS-1], b} - {a[COORD_BITS-1], a});
      return d[COORD_BITS-1:0];
   endfunction

   axis_type                    cx;
   axis_type                    cy;
   logic [COORD_BITS-1:0]       len_x;
   logic [COORD_BITS-1:0]       len_y;
   logic [COORD_BITS-1:0]       len;
   logic [EXTENT_BITS-1:0]      lim;
   logic signed [COORD_BITS:0]  sum_x;
   logic signed [COORD_BITS:0]  sum_y;

   // Axis checks and longest side
   always_comb begin
      cx    = axis_check(ax, bx, box_min_x, box_max_x);
      cy    = axis_check(ay, by, box_min_y, box_max_y);
      len_x = abs_diff(ax, bx);
      len_y = abs_diff(ay, by);
      len   = (len_x > len_y) ? len_x : len_y;
      lim   = (min_extent < EXTENT_FLOOR) ? EXTENT_FLOOR : min_extent;
   end

   // Decision
   always_comb begin
      if (cx == AXIS_DISJOINT || cy == AXIS_DISJOINT) begin
         piece_class = PIECE_MISS;
      end else if (cx == AXIS_INSIDE && cy == AXIS_INSIDE) begin
         piece_class = PIECE_HIT;
      end else if (CMP_BITS'(len) < CMP_BITS'(lim)) begin
         piece_class = PIECE_HIT;
      end else begin
         piece_class = PIECE_SPLIT;
      end
   end

   // Floor of half the endpoint sum
   assign sum_x = {ax[COORD_BITS-1], ax} + {bx[COORD_BITS-1], bx};
   assign sum_y = {ay[COORD_BITS-1], ay} + {by[COORD_BITS-1], by};
   assign mid_x = sum_x[COORD_BITS:1];
   assign mid_y = sum_y[COORD_BITS:1];

endmodule

// ----- sv/segment_box_collision_bisect.sv -----
// After acceptance each piece is classified in turn, and each stack pop reads the piece
// stack RAM, before the result is loaded into the registered rsp_tvalid output.
// Throughput: one segment at a time; the next is taken once the result is registered.
// The loop is set by the single classifier and the registered read of the piece stack RAM.
// An invalid box skips classification and goes straight to the finish state.
// Reset (synchronous, active high) clears control state and sets the box to zero and
// min_extent to 2; the stack RAM needs no clearing since every entry is written first.
module segment_box_collision_bisect #(
   parameter int COORD_BITS  = segbox_pkg::COORD_BITS_DEF,
   parameter int STACK_DEPTH = segbox_pkg::STACK_DEPTH_DEF
) (
   input  logic clock,
   input  logic reset,
   // fields from bit 0: start_x, start_y, end_x, end_y (COORD_BITS each, signed)
   input  logic [((4*COORD_BITS+7)/8)*8-1:0]     req_tdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // fields from bit 0: hit, box_invalid
   output logic [segbox_pkg::RSP_BITS-1:0]       rsp_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_we,
   input  logic [segbox_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [((COORD_BITS > segbox_pkg::EXTENT_BITS) ? COORD_BITS
                  : segbox_pkg::EXTENT_BITS)-1:0] csr_wdata
);
   import segbox_pkg::*;

   localparam int PIECE_BITS = 4 * COORD_BITS;
   localparam int ADDR_BITS  = $clog2(STACK_DEPTH);
   localparam int LVL_BITS   = $clog2(STACK_DEPTH + 1);
   localparam logic [LVL_BITS-1:0] LVL_FULL = LVL_BITS'(STACK_DEPTH);

   // Configuration registers
   logic signed [COORD_BITS-1:0] box_min_x_ff;
   logic signed [COORD_BITS-1:0] box_min_y_ff;
   logic signed [COORD_BITS-1:0] box_max_x_ff;
   logic signed [COORD_BITS-1:0] box_max_y_ff;
   logic [EXTENT_BITS-1:0]       min_extent_ff;

   // Sequencer state
   state_type            state_ff, state_in;
   logic [LVL_BITS-1:0]  lvl_ff, lvl_in;
   logic signed [COORD_BITS-1:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [COORD_BITS-1:0] ax_in, ay_in, bx_in, by_in;
   logic                 res_hit_ff, res_hit_in;
   logic                 res_inv_ff, res_inv_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_hit_ff, out_hit_in;
   logic                 out_inv_ff, out_inv_in;

   // Stack RAM signals
   logic                  ram_we;
   logic [ADDR_BITS-1:0]  ram_waddr;
   logic [PIECE_BITS-1:0] ram_wdata;
   logic [ADDR_BITS-1:0]  ram_raddr;
   logic [PIECE_BITS-1:0] ram_rdata;

   // Classifier signals
   piece_class_type              piece_class;
   logic signed [COORD_BITS-1:0] mid_x;
   logic signed [COORD_BITS-1:0] mid_y;

   logic req_fire;
   logic box_bad;
   logic [LVL_BITS-1:0] lvl_dec;

   // Configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         box_min_x_ff  <= '0;
         box_min_y_ff  <= '0;
         box_max_x_ff  <= '0;
         box_max_y_ff  <= '0;
         min_extent_ff <= EXTENT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_BOX_MIN_X:  box_min_x_ff  <= csr_wdata[COORD_BITS-1:0];
            CSR_BOX_MIN_Y:  box_min_y_ff  <= csr_wdata[COORD_BITS-1:0];
            CSR_BOX_MAX_X:  box_max_x_ff  <= csr_wdata[COORD_BITS-1:0];
            CSR_BOX_MAX_Y:  box_max_y_ff  <= csr_wdata[COORD_BITS-1:0];
            CSR_MIN_EXTENT: min_extent_ff <= csr_wdata[EXTENT_BITS-1:0];
            default: ;
         endcase
      end
   end

   segbox_classify #(
      .COORD_BITS (COORD_BITS)
   ) u_classify (
      .ax          (ax_ff),
      .ay          (ay_ff),
      .bx          (bx_ff),
      .by          (by_ff),
      .box_min_x   (box_min_x_ff),
      .box_min_y   (box_min_y_ff),
      .box_max_x   (box_max_x_ff),
      .box_max_y   (box_max_y_ff),
      .min_extent  (min_extent_ff),
      .piece_class (piece_class),
      .mid_x       (mid_x),
      .mid_y       (mid_y)
   );

   segbox_ram #(
      .WIDTH (PIECE_BITS),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign box_bad    = (box_min_x_ff > box_max_x_ff) || (box_min_y_ff > box_max_y_ff);
   assign lvl_dec    = lvl_ff - LVL_BITS'(1);

   // Stack push writes the second half at the current level
   assign ram_waddr = lvl_ff[ADDR_BITS-1:0];
   assign ram_wdata = {by_ff, bx_ff, mid_y, mid_x};
   assign ram_raddr = lvl_dec[ADDR_BITS-1:0];

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      lvl_in       = lvl_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      res_hit_in   = res_hit_ff;
      res_inv_in   = res_inv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      out_hit_in   = out_hit_ff;
      out_inv_in   = out_inv_ff;
      ram_we       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               ax_in      = req_tdata[COORD_BITS-1:0];
               ay_in      = req_tdata[2*COORD_BITS-1:COORD_BITS];
               bx_in      = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
               by_in      = req_tdata[4*COORD_BITS-1:3*COORD_BITS];
               lvl_in     = '0;
               res_hit_in = 1'b0;
               res_inv_in = box_bad;
               state_in   = box_bad ? ST_FINISH : ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            case (piece_class)
               PIECE_HIT: begin
                  res_hit_in = 1'b1;
                  state_in   = ST_FINISH;
               end
               PIECE_MISS: begin
                  if (lvl_ff == '0) begin
                     state_in = ST_FINISH;
                  end else begin
                     // read address is lvl_ff - 1, data back next cycle
                     lvl_in   = lvl_dec;
                     state_in = ST_POP;
                  end
               end
               PIECE_SPLIT: begin
                  if (lvl_ff == LVL_FULL) begin
                     // no room to split: counts as a hit
                     res_hit_in = 1'b1;
                     state_in   = ST_FINISH;
                  end else begin
                     ram_we = 1'b1;
                     lvl_in = lvl_ff + LVL_BITS'(1);
                     bx_in  = mid_x;
                     by_in  = mid_y;
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_POP: begin
            ax_in    = ram_rdata[COORD_BITS-1:0];
            ay_in    = ram_rdata[2*COORD_BITS-1:COORD_BITS];
            bx_in    = ram_rdata[3*COORD_BITS-1:2*COORD_BITS];
            by_in    = ram_rdata[4*COORD_BITS-1:3*COORD_BITS];
            state_in = ST_CLASSIFY;
         end
         ST_FINISH: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               out_hit_in   = res_hit_ff;
               out_inv_in   = res_inv_ff;
               lvl_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lvl_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lvl_ff       <= lvl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      bx_ff      <= bx_in;
      by_ff      <= by_in;
      res_hit_ff <= res_hit_in;
      res_inv_ff <= res_inv_in;
      out_hit_ff <= out_hit_in;
      out_inv_ff <= out_inv_in;
   end

   // Result item
   always_comb begin
      rsp_tdata                  = '0;
      rsp_tdata[RSP_HIT_BIT]     = out_hit_ff;
      rsp_tdata[RSP_INVALID_BIT] = out_inv_ff;
   end
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- sim/segment_box_collision_bisect_checker.sv -----
// Result checker for the segment versus box bisection block: tracks config, predicts, compares.
`timescale 1ns / 1ps

module segment_box_collision_bisect_checker (
   input  logic                                              clock,
   input  logic                                              reset,
   // fields from bit 0: start_x, start_y, end_x, end_y
   input  logic [((4*segbox_pkg::COORD_BITS_DEF+7)/8)*8-1:0] req_tdata,
   input  logic                                              req_tvalid,
   input  logic                                              req_tready,
   // fields from bit 0: hit, box_invalid
   input  logic [segbox_pkg::RSP_BITS-1:0]                   rsp_tdata,
   input  logic                                              rsp_tvalid,
   input  logic                                              rsp_tready,
   input  logic                                              csr_we,
   input  logic [segbox_pkg::CSR_ADDR_BITS-1:0]              csr_addr,
   input  logic [segbox_pkg::EXTENT_BITS-1:0]                csr_wdata,
   output int                                                fail_count,
   output int                                                pending
);
   import segbox_pkg::*;

   localparam int REQ_BITS = ((4*COORD_BITS_DEF+7)/8)*8;

   typedef logic signed [COORD_BITS_DEF-1:0] coord_type;
   typedef logic signed [COORD_BITS_DEF:0]   wide_type;
   typedef logic [COORD_BITS_DEF:0]          length_type;

   typedef struct packed {
      coord_type ax;
      coord_type ay;
      coord_type bx;
      coord_type by;
   } piece_type;

   typedef struct packed {
      logic box_invalid;
      logic hit;
   } verdict_type;

   // Local copy of the block's registers
   coord_type              box_lo_x;
   coord_type              box_lo_y;
   coord_type              box_hi_x;
   coord_type              box_hi_y;
   logic [EXTENT_BITS-1:0] split_limit;

   // Outcomes of accepted segments, oldest first
   verdict_type outcome_q[$];
   verdict_type want;

   // Where an interval lies against the box on one axis
   function automatic axis_type axis_relation(coord_type a, coord_type b,
                                              coord_type lo, coord_type hi);
      coord_type near_end;
      coord_type far_end;
      near_end = (a < b) ? a : b;
      far_end  = (a < b) ? b : a;
      if (far_end < lo || hi < near_end)
         return AXIS_DISJOINT;
      if (lo <= near_end && far_end <= hi)
         return AXIS_INSIDE;
      return AXIS_OVERLAP;
   endfunction

   // Distance between two coordinates, one bit wider than a coordinate
   function automatic length_type span(coord_type a, coord_type b);
      wide_type wa;
      wide_type wb;
      wa = a;
      wb = b;
      return (wa > wb) ? length_type'(wa - wb) : length_type'(wb - wa);
   endfunction

   // Floor of half the sum
   function automatic coord_type midpoint(coord_type a, coord_type b);
      wide_type wa;
      wide_type wb;
      wide_type total;
      wa = a;
      wb = b;
      total = wa + wb;
      return coord_type'(total >>> 1);
   endfunction

   function automatic piece_class_type classify_piece(piece_type p);
      axis_type   rel_x;
      axis_type   rel_y;
      length_type len_x;
      length_type len_y;
      length_type longest;
      length_type floor_len;
      rel_x = axis_relation(p.ax, p.bx, box_lo_x, box_hi_x);
      rel_y = axis_relation(p.ay, p.by, box_lo_y, box_hi_y);
      if (rel_x == AXIS_DISJOINT || rel_y == AXIS_DISJOINT)
         return PIECE_MISS;
      if (rel_x == AXIS_INSIDE && rel_y == AXIS_INSIDE)
         return PIECE_HIT;
      len_x = span(p.ax, p.bx);
      len_y = span(p.ay, p.by);
      longest = (len_x > len_y) ? len_x : len_y;
      // min_extent below the floor acts as the floor
      floor_len = length_type'((split_limit < EXTENT_FLOOR) ? EXTENT_FLOOR : split_limit);
      return (longest < floor_len) ? PIECE_HIT : PIECE_SPLIT;
   endfunction

   // Depth-first bisection of one segment against the current box
   function automatic verdict_type segment_outcome(logic [REQ_BITS-1:0] item);
      piece_type       deferred [STACK_DEPTH_DEF];
      piece_type       cur;
      piece_type       upper;
      piece_class_type cls;
      int unsigned     level;
      coord_type       mid_x;
      coord_type       mid_y;
      verdict_type     res;
      res = '0;
      if (box_lo_x > box_hi_x || box_lo_y > box_hi_y) begin
         res.box_invalid = 1'b1;
         return res;
      end
      cur.ax = item[0*COORD_BITS_DEF +: COORD_BITS_DEF];
      cur.ay = item[1*COORD_BITS_DEF +: COORD_BITS_DEF];
      cur.bx = item[2*COORD_BITS_DEF +: COORD_BITS_DEF];
      cur.by = item[3*COORD_BITS_DEF +: COORD_BITS_DEF];
      level = 0;
      while (1'b1) begin
         cls = classify_piece(cur);
         if (cls == PIECE_HIT) begin
            res.hit = 1'b1;
            break;
         end else if (cls == PIECE_MISS) begin
            if (level == 0)
               break;
            level--;
            cur = deferred[level];
         end else if (level >= STACK_DEPTH_DEF) begin
            // no room left to defer: counted as a hit
            res.hit = 1'b1;
            break;
         end else begin
            mid_x = midpoint(cur.ax, cur.bx);
            mid_y = midpoint(cur.ay, cur.by);
            upper.ax = mid_x;
            upper.ay = mid_y;
            upper.bx = cur.bx;
            upper.by = cur.by;
            deferred[level] = upper;
            level++;
            cur.bx = mid_x;
            cur.by = mid_y;
         end
      end
      return res;
   endfunction

   // Channel monitor: config writes, results against the oldest outcome, new segments
   always @(posedge clock) begin
      if (reset) begin
         box_lo_x    = '0;
         box_lo_y    = '0;
         box_hi_x    = '0;
         box_hi_y    = '0;
         split_limit = EXTENT_RESET;
         outcome_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_BOX_MIN_X:  box_lo_x = coord_type'(csr_wdata);
               CSR_BOX_MIN_Y:  box_lo_y = coord_type'(csr_wdata);
               CSR_BOX_MAX_X:  box_hi_x = coord_type'(csr_wdata);
               CSR_BOX_MAX_Y:  box_hi_y = coord_type'(csr_wdata);
               CSR_MIN_EXTENT: split_limit = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_q.size() == 0) begin
               fail_count++;
               $display("%0t: result with none expected: hit=%0b box_invalid=%0b",
                        $time, rsp_tdata[RSP_HIT_BIT], rsp_tdata[RSP_INVALID_BIT]);
            end else begin
               want = outcome_q.pop_front();
               if (rsp_tdata[RSP_HIT_BIT] !== want.hit ||
                   rsp_tdata[RSP_INVALID_BIT] !== want.box_invalid) begin
                  fail_count++;
                  $display({"%0t: wrong result: expected hit=%0b box_invalid=%0b,",
                            " got hit=%0b box_invalid=%0b"},
                           $time, want.hit, want.box_invalid,
                           rsp_tdata[RSP_HIT_BIT], rsp_tdata[RSP_INVALID_BIT]);
               end
            end
         end
         if (req_tvalid && req_tready)
            outcome_q.push_back(segment_outcome(req_tdata));
      end
      pending = outcome_q.size();
   end

endmodule

// ----- sim/tb_segment_box_collision_bisect.sv -----
// Testbench top: clock, reset, segment and config stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_segment_box_collision_bisect;
   import segbox_pkg::*;

   localparam int REQ_BITS      = ((4*COORD_BITS_DEF+7)/8)*8;
   localparam int CSR_DATA_BITS = (COORD_BITS_DEF > EXTENT_BITS) ? COORD_BITS_DEF : EXTENT_BITS;
   localparam int COORD_MIN     = -(1 << (COORD_BITS_DEF-1));
   localparam int COORD_MAX     = (1 << (COORD_BITS_DEF-1)) - 1;
   localparam int EXTENT_MAX    = (1 << EXTENT_BITS) - 1;
   localparam int HOLD_CYCLES   = 400;
   localparam int ROUNDS        = 14;
   localparam int ROUND_ITEMS   = 107;

   // Register indexes that map to nothing
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE_HI = 3'd7;

   typedef logic signed [COORD_BITS_DEF-1:0] coord_type;

   // start_x sits in the lowest bits
   typedef struct packed {
      coord_type end_y;
      coord_type end_x;
      coord_type start_y;
      coord_type start_x;
   } segment_type;

   logic                     clock;
   logic                     reset;
   logic [REQ_BITS-1:0]      req_tdata;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [RSP_BITS-1:0]      rsp_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic                     csr_we;
   logic [CSR_ADDR_BITS-1:0] csr_addr;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   int fail_count;
   int pending;

   // Box as last programmed, used only to aim segments
   int box_x0 = 0;
   int box_y0 = 0;
   int box_x1 = 0;
   int box_y1 = 0;

   bit tx_calm = 1'b0;
   bit rx_calm = 1'b0;
   bit rx_hold_request = 1'b0;

   segment_box_collision_bisect DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   segment_box_collision_bisect_checker collision_check (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #40_000_000;
      $display("segment_box_collision_bisect: mismatch");
      $finish;
   end

   function automatic int clamp_coord(int v);
      if (v < COORD_MIN)
         return COORD_MIN;
      if (v > COORD_MAX)
         return COORD_MAX;
      return v;
   endfunction

   function automatic int any_coord();
      return int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
   endfunction

   // Uniform pick within the interval widened by margin
   function automatic int near_coord(int a, int b, int margin);
      int lo;
      int hi;
      lo = clamp_coord(((a < b) ? a : b) - margin);
      hi = clamp_coord(((a < b) ? b : a) + margin);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // Field extremes and box edges
   function automatic int edge_coord(int lo, int hi);
      case ($urandom_range(0, 7))
         0: return COORD_MIN;
         1: return COORD_MAX;
         2: return 0;
         3: return -1;
         4: return lo;
         5: return hi;
         6: return clamp_coord(lo - 1);
         default: return clamp_coord(hi + 1);
      endcase
   endfunction

   function automatic segment_type segment_of(int sx, int sy, int ex, int ey);
      segment_type s;
      s.start_x = coord_type'(sx);
      s.start_y = coord_type'(sy);
      s.end_x   = coord_type'(ex);
      s.end_y   = coord_type'(ey);
      return s;
   endfunction

   // Mostly segments around the box, some anywhere, some on extremes
   function automatic segment_type random_segment();
      int margin;
      int sx;
      int sy;
      int ex;
      int ey;
      margin = $urandom_range(0, 1 << $urandom_range(0, 14));
      case ($urandom_range(0, 9))
         0, 1: begin
            sx = any_coord();
            sy = any_coord();
            ex = any_coord();
            ey = any_coord();
         end
         2, 3, 4, 5: begin
            sx = near_coord(box_x0, box_x1, margin);
            sy = near_coord(box_y0, box_y1, margin);
            ex = near_coord(box_x0, box_x1, margin);
            ey = near_coord(box_y0, box_y1, margin);
         end
         6, 7: begin
            sx = near_coord(box_x0, box_x1, 0);
            sy = near_coord(box_y0, box_y1, 0);
            ex = any_coord();
            ey = any_coord();
         end
         8: begin
            sx = near_coord(box_x0, box_x1, margin);
            sy = near_coord(box_y0, box_y1, margin);
            ex = sx;
            ey = sy;
         end
         default: begin
            sx = edge_coord(box_x0, box_x1);
            sy = edge_coord(box_y0, box_y1);
            ex = edge_coord(box_x0, box_x1);
            ey = edge_coord(box_y0, box_y1);
         end
      endcase
      return segment_of(sx, sy, ex, ey);
   endfunction

   // Offer one item after a random gap and wait for it to be taken
   task automatic push_segment(segment_type s);
      int gap;
      if ($urandom_range(0, 39) == 0)
         tx_calm = !tx_calm;
      gap = tx_calm ? 0 : $urandom_range(0, 19);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= s;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // Wait until every result is back and the block has gone idle
   task automatic settle();
      do @(negedge clock); while (pending != 0);
      repeat (8) @(negedge clock);
   endtask

   // Write the five registers back to back, optionally with a stray index in between
   task automatic program_box(int lo_x, int lo_y, int hi_x, int hi_y, int extent, bit spare);
      logic [CSR_ADDR_BITS-1:0] addr_list [6];
      logic [CSR_DATA_BITS-1:0] data_list [6];
      int                       count;
      addr_list[0] = CSR_BOX_MIN_X;
      data_list[0] = CSR_DATA_BITS'(lo_x);
      addr_list[1] = CSR_BOX_MIN_Y;
      data_list[1] = CSR_DATA_BITS'(lo_y);
      addr_list[2] = CSR_BOX_MAX_X;
      data_list[2] = CSR_DATA_BITS'(hi_x);
      addr_list[3] = CSR_BOX_MAX_Y;
      data_list[3] = CSR_DATA_BITS'(hi_y);
      addr_list[4] = CSR_MIN_EXTENT;
      data_list[4] = CSR_DATA_BITS'(extent);
      count = 5;
      if (spare) begin
         addr_list[5] = addr_list[4];
         data_list[5] = data_list[4];
         addr_list[4] = CSR_ADDR_BITS'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI));
         data_list[4] = CSR_DATA_BITS'($urandom);
         count = 6;
      end
      for (int i = 0; i < count; i++) begin
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_addr  <= addr_list[i];
         csr_wdata <= data_list[i];
      end
      @(negedge clock);
      csr_we <= 1'b0;
      box_x0 = lo_x;
      box_y0 = lo_y;
      box_x1 = hi_x;
      box_y1 = hi_y;
   endtask

   // New box and split limit for one random round
   task automatic random_setup(int round);
      int lo_x;
      int lo_y;
      int hi_x;
      int hi_y;
      int extent;
      int a;
      int b;
      if (round == 0) begin
         program_box(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, EXTENT_MAX, 1'b0);
         return;
      end
      if (round == 1) begin
         a = any_coord();
         b = any_coord();
         program_box(a, b, a, b, 0, 1'b1);
         return;
      end
      lo_x = any_coord();
      lo_y = any_coord();
      hi_x = clamp_coord(lo_x + $urandom_range(0, 1 << $urandom_range(0, 14)));
      hi_y = clamp_coord(lo_y + $urandom_range(0, 1 << $urandom_range(0, 14)));
      case ($urandom_range(0, 7))
         0: begin
            // corners swapped on one or both axes
            a = lo_x;
            lo_x = (hi_x > lo_x) ? hi_x : clamp_coord(lo_x + 1);
            hi_x = (lo_x > a) ? a : clamp_coord(lo_x - 1);
            if ($urandom_range(0, 1)) begin
               a = lo_y;
               lo_y = hi_y;
               hi_y = a;
            end
         end
         1: begin
            lo_x = COORD_MIN;
            lo_y = COORD_MIN;
            hi_x = COORD_MAX;
            hi_y = COORD_MAX;
         end
         2: begin
            // zero-width box on one axis
            if ($urandom_range(0, 1))
               hi_x = lo_x;
            else
               hi_y = lo_y;
         end
         default: ;
      endcase
      case ($urandom_range(0, 7))
         0: extent = 0;
         1: extent = 1;
         2: extent = 2;
         3: extent = EXTENT_MAX;
         4: extent = $urandom_range(0, EXTENT_MAX);
         default: extent = $urandom_range(2, 64);
      endcase
      program_box(lo_x, lo_y, hi_x, hi_y, extent, $urandom_range(0, 2) == 0);
   endtask

   // Receiver: random stall before each result, sometimes one very long hold
   initial begin
      int stall;
      rsp_tready = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 39) == 0)
            rx_calm = !rx_calm;
         if (rx_hold_request) begin
            stall = HOLD_CYCLES;
            rx_hold_request = 1'b0;
         end else begin
            stall = rx_calm ? 0 : $urandom_range(0, 19);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Stimulus and verdict
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_addr   = '0;
      csr_wdata  = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Reset box: a single point at the origin
      push_segment(segment_of(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
      push_segment(segment_of(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
      push_segment(segment_of(1, 1, 5, 9));
      push_segment(segment_of(0, 0, 0, 0));
      end_burst();
      settle();

      // Ordinary box, with a write to an unmapped index
      program_box(-100, -50, 200, 300, 2, 1'b1);
      push_segment(segment_of(0, 0, 10, 10));
      push_segment(segment_of(-1000, 100, 1000, 100));
      push_segment(segment_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX));
      push_segment(segment_of(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN));
      push_segment(segment_of(-300, 350, 250, -150));
      push_segment(segment_of(200, 300, 200, 300));
      push_segment(segment_of(201, 300, 201, 300));
      push_segment(segment_of(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
      end_burst();
      settle();

      // Invalid box on x, then on y
      program_box(10, -5, -10, 5, 2, 1'b0);
      push_segment(segment_of(0, 0, 0, 0));
      push_segment(segment_of(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
      end_burst();
      settle();
      program_box(-5, 10, 5, -10, 2, 1'b0);
      push_segment(segment_of(-3, 0, 3, 0));
      end_burst();
      settle();

      // Split limit below the floor, then at its maximum
      program_box(-20, -20, 20, 20, 0, 1'b0);
      push_segment(segment_of(-30, 19, 30, 21));
      end_burst();
      settle();
      program_box(-20, -20, 20, 20, 1, 1'b0);
      push_segment(segment_of(-25, -21, 25, -22));
      end_burst();
      settle();
      program_box(-20, -20, 20, 20, EXTENT_MAX, 1'b0);
      push_segment(segment_of(COORD_MIN, 0, COORD_MAX, 0));
      push_segment(segment_of(-21, -21, 21, 21));
      end_burst();
      settle();

      // Box covering the whole plane
      program_box(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 2, 1'b0);
      push_segment(segment_of(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN));
      push_segment(segment_of(-1, -1, -1, -1));
      end_burst();
      settle();

      // Random rounds, each under a fresh configuration
      for (int round = 0; round < ROUNDS; round++) begin
         random_setup(round);
         if (round == 3 || round == 9) begin
            rx_hold_request = 1'b1;
            tx_calm = 1'b1;
         end
         for (int n = 0; n < ROUND_ITEMS; n++)
            push_segment(random_segment());
         end_burst();
         settle();
      end

      do @(negedge clock); while (pending != 0);
      repeat (100) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("segment_box_collision_bisect: match");
      else
         $display("segment_box_collision_bisect: mismatch");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/segbox_pkg.sv
sv/segbox_ram.sv
sv/segbox_classify.sv
sv/segment_box_collision_bisect.sv
sim/segment_box_collision_bisect_checker.sv
sim/tb_segment_box_collision_bisect.sv
